[rtl/ehash_pkg.sv]
// Shared types, constants and hash helpers of the extendible hash table.
package ehash_pkg;

  localparam int BUCKET_LIMIT_DEF   = 25;
  localparam int SLOTS_PER_PAGE_DEF = 32;
  localparam int MAX_DEPTH_DEF      = 6;
  localparam int KEY_BYTES_DEF      = 8;

  localparam logic [31:0] HASH_SEED = 32'h238F13AF;
  localparam logic [31:0] HASH_MASK = 32'h7FFFFFFF;

  localparam logic [0:0] REQ_PUT = 1'b0;
  localparam logic [0:0] REQ_GET = 1'b1;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_HIT     = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_NO_ROOM = 3'd4;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [63:0] put_value;
  } ehash_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
  } ehash_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIR_RD,
    OP_DIR_RD2,
    OP_PG_RD,
    OP_PG_CAP,
    OP_DBL_RD,
    OP_DBL_WR,
    OP_GD_INC,
    OP_SPL_INIT,
    OP_SL_RD,
    OP_HASH_SLOT,
    OP_SPL_WR,
    OP_SPL_FIN1,
    OP_SPL_FIN2,
    OP_RD_RD,
    OP_RD_WR,
    OP_CMP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic hash_done;
    logic is_get;
    logic split_ok;
    logic ld_eq_gd;
    logic cnt_zero;
    logic dbl_last;
    logic spl_last;
    logic rd_last;
    logic cmp_hit;
    logic cmp_last;
    logic out_free;
  } dp_status_t;

  // Shift of byte i in the hash: (5*i) mod 24.
  function automatic logic [4:0] hash_shift(input logic [2:0] idx);
    logic [4:0] sh;
    unique case (idx)
      3'd0: sh = 5'd0;
      3'd1: sh = 5'd5;
      3'd2: sh = 5'd10;
      3'd3: sh = 5'd15;
      3'd4: sh = 5'd20;
      3'd5: sh = 5'd1;
      3'd6: sh = 5'd6;
      3'd7: sh = 5'd11;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

[rtl/ehash_hash.sv]
// Iterative key hash unit: one key byte per cycle.
module ehash_hash import ehash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  input  logic [3:0]  len,
  output logic        busy,
  output logic [31:0] hres
);

  logic        busy_r;
  logic [63:0] key_r;
  logic [3:0]  len_r;
  logic [3:0]  idx_r;
  logic [31:0] acc_r;
  logic [7:0]  cur_byte;
  logic [31:0] addend;

  assign cur_byte = key_r[{idx_r[2:0], 3'b000} +: 8];
  assign addend   = {{24{cur_byte[7]}}, cur_byte} << hash_shift(idx_r[2:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= (len != 4'd0);
    end else if (busy_r) begin
      busy_r <= ((idx_r + 4'd1) != len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
      len_r <= len;
      idx_r <= 4'd0;
      acc_r <= HASH_SEED * {28'd0, len};
    end else if (busy_r) begin
      idx_r <= idx_r + 4'd1;
      acc_r <= (acc_r + addend) & HASH_MASK;
    end
  end

  assign busy = busy_r;
  assign hres = acc_r;

endmodule

[rtl/ehash_dp.sv]
// Datapath: request registers, directory, page table, slot memory, counters.
module ehash_dp import ehash_pkg::*; #(
  parameter int BUCKET_LIMIT   = BUCKET_LIMIT_DEF,
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF,
  parameter int MAX_DEPTH      = MAX_DEPTH_DEF,
  parameter int KEY_BYTES      = KEY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_op_t     op,
  input  ehash_in_t  in_data,
  output dp_status_t st,
  output logic       out_valid,
  input  logic       out_ready,
  output ehash_out_t out_data
);

  localparam int PC    = 1 << MAX_DEPTH;
  localparam int PW    = MAX_DEPTH;
  localparam int LW    = $clog2(MAX_DEPTH + 1);
  localparam int CW    = $clog2(SLOTS_PER_PAGE + 1);
  localparam int IW    = (PW > CW) ? PW : CW;
  localparam int NSLOT = PC * SLOTS_PER_PAGE;
  localparam int AW    = $clog2(NSLOT);

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] val;
    logic [3:0]  len;
  } slot_t;

  typedef struct packed {
    logic [LW-1:0] ld;
    logic [CW-1:0] cnt;
  } page_t;

  // Request registers
  logic          req_r;
  logic [63:0]   key_r;
  logic [63:0]   val_r;
  logic [3:0]    len_r;
  logic [31:0]   h_r;

  // Table state
  logic [LW-1:0] gd_r;
  logic [PW:0]   pages_used_r;
  logic [PW-1:0] p_r;
  logic [PW-1:0] q_r;
  logic [LW-1:0] ld_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] i_r;
  logic [CW-1:0] keep_r;
  logic [CW-1:0] moved_r;
  logic          found_r;
  logic [63:0]   fval_r;

  logic          out_valid_r;
  ehash_out_t    out_data_r;

  // Memories
  logic [PW-1:0] dir_mem [PC];
  logic [PC-1:0] dir_vld_r;
  logic [PW-1:0] dir_rd_r;
  page_t         pg_mem [PC];
  logic [PC-1:0] pg_vld_r;
  page_t         pg_rd_r;
  slot_t         slot_mem [NSLOT];
  slot_t         slot_rd_r;

  // Load-side key clamp and mask
  logic [3:0]    lenc;
  logic [63:0]   keym;

  always_comb begin
    lenc = (in_data.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_data.key_len;
    for (int b = 0; b < 8; b++) begin
      keym[8*b +: 8] = (4'(b) < lenc) ? in_data.key_bytes[8*b +: 8] : 8'd0;
    end
  end

  // Hash unit
  logic        h_start;
  logic [63:0] h_key;
  logic [3:0]  h_len;
  logic        h_busy;
  logic [31:0] hres;

  assign h_start = (op == OP_LOAD) || (op == OP_HASH_SLOT);
  assign h_key   = (op == OP_LOAD) ? keym : slot_rd_r.key;
  assign h_len   = (op == OP_LOAD) ? lenc : slot_rd_r.len;

  ehash_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .key   (h_key),
    .len   (h_len),
    .busy  (h_busy),
    .hres  (hres)
  );

  // Directory geometry
  logic [PW:0]   dsize;
  logic [PW-1:0] dmask;
  assign dsize = (PW+1)'(1) << gd_r;
  assign dmask = PW'(dsize - (PW+1)'(1));

  // Directory port
  logic          dir_re;
  logic [PW-1:0] dir_ra;
  logic          dir_we;
  logic [PW-1:0] dir_wa;
  logic [PW-1:0] dir_wd;

  always_comb begin
    dir_re = 1'b0;
    dir_ra = i_r[PW-1:0];
    dir_we = 1'b0;
    dir_wa = i_r[PW-1:0];
    dir_wd = q_r;
    unique case (op)
      OP_DIR_RD: begin
        dir_re = 1'b1;
        dir_ra = hres[PW-1:0] & dmask;
      end
      OP_DIR_RD2: begin
        dir_re = 1'b1;
        dir_ra = h_r[PW-1:0] & dmask;
      end
      OP_DBL_RD, OP_RD_RD: dir_re = 1'b1;
      OP_DBL_WR: begin
        dir_we = 1'b1;
        dir_wa = PW'(dsize + (PW+1)'(i_r[PW-1:0]));
        dir_wd = dir_rd_r;
      end
      OP_RD_WR: dir_we = (dir_rd_r == p_r) && i_r[ld_r];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (dir_re) dir_rd_r <= dir_vld_r[dir_ra] ? dir_mem[dir_ra] : '0;
  end

  // Page table port
  logic          pg_we;
  logic [PW-1:0] pg_wa;
  page_t         pg_wd;
  logic          ins;

  assign ins = (req_r == REQ_PUT) && !found_r && (cnt_r < CW'(SLOTS_PER_PAGE));

  always_comb begin
    pg_we = 1'b0;
    pg_wa = p_r;
    pg_wd = '{ld: ld_r + LW'(1), cnt: keep_r};
    unique case (op)
      OP_SPL_FIN1: pg_we = 1'b1;
      OP_SPL_FIN2: begin
        pg_we = 1'b1;
        pg_wa = q_r;
        pg_wd = '{ld: ld_r + LW'(1), cnt: moved_r};
      end
      OP_FINISH: begin
        pg_we = ins;
        pg_wd = '{ld: ld_r, cnt: cnt_r + CW'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pg_we) pg_mem[pg_wa] <= pg_wd;
    if (op == OP_PG_RD) pg_rd_r <= pg_vld_r[dir_rd_r] ? pg_mem[dir_rd_r] : '0;
  end

  // Valid bits stand in for the reset value of directory and page table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_vld_r <= '0;
      pg_vld_r  <= '0;
    end else begin
      if (dir_we) dir_vld_r[dir_wa] <= 1'b1;
      if (pg_we)  pg_vld_r[pg_wa]   <= 1'b1;
    end
  end

  // Slot memory port
  logic [AW-1:0] p_base;
  logic [AW-1:0] q_base;
  logic [AW-1:0] sl_a;
  logic          sl_we;
  slot_t         sl_wd;
  logic          mv_bit;

  assign p_base = AW'(p_r) * AW'(SLOTS_PER_PAGE);
  assign q_base = AW'(q_r) * AW'(SLOTS_PER_PAGE);
  assign mv_bit = hres[ld_r];

  always_comb begin
    sl_a  = p_base + AW'(i_r);
    sl_we = 1'b0;
    sl_wd = slot_rd_r;
    unique case (op)
      OP_SPL_WR: begin
        sl_we = 1'b1;
        sl_a  = mv_bit ? (q_base + AW'(moved_r)) : (p_base + AW'(keep_r));
      end
      OP_FINISH: begin
        sl_we = ins;
        sl_a  = p_base + AW'(cnt_r);
        sl_wd = '{key: key_r, val: val_r, len: len_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sl_we) slot_mem[sl_a] <= sl_wd;
    if (op == OP_SL_RD) slot_rd_r <= slot_mem[sl_a];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gd_r         <= '0;
      pages_used_r <= (PW+1)'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (op == OP_GD_INC)   gd_r <= gd_r + LW'(1);
      if (op == OP_SPL_FIN2) pages_used_r <= pages_used_r + (PW+1)'(1);
      if (op == OP_FINISH)   out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        req_r <= in_data.req_type;
        key_r <= keym;
        len_r <= lenc;
        val_r <= in_data.put_value;
      end
      OP_DIR_RD: h_r <= hres;
      OP_PG_RD:  p_r <= dir_rd_r;
      OP_PG_CAP: begin
        ld_r    <= pg_rd_r.ld;
        cnt_r   <= pg_rd_r.cnt;
        i_r     <= '0;
        found_r <= 1'b0;
      end
      OP_DBL_WR: i_r <= i_r + IW'(1);
      OP_GD_INC: i_r <= '0;
      OP_SPL_INIT: begin
        q_r     <= pages_used_r[PW-1:0];
        i_r     <= '0;
        keep_r  <= '0;
        moved_r <= '0;
      end
      OP_SPL_WR: begin
        i_r <= i_r + IW'(1);
        if (mv_bit) moved_r <= moved_r + CW'(1);
        else        keep_r  <= keep_r + CW'(1);
      end
      OP_SPL_FIN2: i_r <= '0;
      OP_RD_WR:    i_r <= i_r + IW'(1);
      OP_CMP: begin
        i_r <= i_r + IW'(1);
        if (st.cmp_hit) begin
          found_r <= 1'b1;
          fval_r  <= slot_rd_r.val;
        end
      end
      OP_FINISH: begin
        if (req_r == REQ_GET) begin
          out_data_r.status     <= found_r ? ST_HIT : ST_MISS;
          out_data_r.read_value <= found_r ? fval_r : 64'd0;
        end else begin
          out_data_r.status     <= found_r ? ST_PRESENT : (ins ? ST_STORED : ST_NO_ROOM);
          out_data_r.read_value <= 64'd0;
        end
      end
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    st.hash_done = !h_busy;
    st.is_get    = (req_r == REQ_GET);
    st.split_ok  = (32'(cnt_r) > 32'(BUCKET_LIMIT)) && (pages_used_r < (PW+1)'(PC)) &&
                   ((ld_r < gd_r) || (gd_r < LW'(MAX_DEPTH)));
    st.ld_eq_gd  = (ld_r == gd_r);
    st.cnt_zero  = (cnt_r == '0);
    st.dbl_last  = (i_r == IW'(dsize - (PW+1)'(1)));
    st.rd_last   = (i_r == IW'(dsize - (PW+1)'(1)));
    st.spl_last  = ((i_r + IW'(1)) == IW'(cnt_r));
    st.cmp_hit   = (slot_rd_r.len == len_r) && (slot_rd_r.key == key_r);
    st.cmp_last  = ((i_r + IW'(1)) == IW'(cnt_r));
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/ehash_ctrl.sv]
// Controller state machine: sequences lookup, directory doubling and page split.
module ehash_ctrl import ehash_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_op_t     op
);

  typedef enum logic [4:0] {
    S_IDLE, S_HWAIT, S_PGRD, S_PGCAP, S_DECIDE,
    S_DBLRD, S_DBLWR, S_GDINC, S_SPINIT, S_SPRD, S_SPHS, S_SPHW,
    S_SPFIN1, S_SPFIN2, S_RDRD, S_RDWR, S_DIR2, S_FRD, S_FCMP, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   split_done_r;

  always_comb begin
    op        = OP_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        op        = OP_LOAD;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: if (st.hash_done) begin
        op        = OP_DIR_RD;
        state_nxt = S_PGRD;
      end
      S_PGRD: begin
        op        = OP_PG_RD;
        state_nxt = S_PGCAP;
      end
      S_PGCAP: begin
        op        = OP_PG_CAP;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (!st.is_get && !split_done_r && st.split_ok)
          state_nxt = st.ld_eq_gd ? S_DBLRD : S_SPINIT;
        else if (st.cnt_zero)
          state_nxt = S_FIN;
        else
          state_nxt = S_FRD;
      end
      S_DBLRD: begin
        op        = OP_DBL_RD;
        state_nxt = S_DBLWR;
      end
      S_DBLWR: begin
        op        = OP_DBL_WR;
        state_nxt = st.dbl_last ? S_GDINC : S_DBLRD;
      end
      S_GDINC: begin
        op        = OP_GD_INC;
        state_nxt = S_SPINIT;
      end
      S_SPINIT: begin
        op        = OP_SPL_INIT;
        state_nxt = S_SPRD;
      end
      S_SPRD: begin
        op        = OP_SL_RD;
        state_nxt = S_SPHS;
      end
      S_SPHS: begin
        op        = OP_HASH_SLOT;
        state_nxt = S_SPHW;
      end
      S_SPHW: if (st.hash_done) begin
        op        = OP_SPL_WR;
        state_nxt = st.spl_last ? S_SPFIN1 : S_SPRD;
      end
      S_SPFIN1: begin
        op        = OP_SPL_FIN1;
        state_nxt = S_SPFIN2;
      end
      S_SPFIN2: begin
        op        = OP_SPL_FIN2;
        state_nxt = S_RDRD;
      end
      S_RDRD: begin
        op        = OP_RD_RD;
        state_nxt = S_RDWR;
      end
      S_RDWR: begin
        op        = OP_RD_WR;
        state_nxt = st.rd_last ? S_DIR2 : S_RDRD;
      end
      S_DIR2: begin
        op        = OP_DIR_RD2;
        state_nxt = S_PGRD;
      end
      S_FRD: begin
        op        = OP_SL_RD;
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        op        = OP_CMP;
        state_nxt = (st.cmp_hit || st.cmp_last) ? S_FIN : S_FRD;
      end
      S_FIN: if (st.out_free) begin
        op        = OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      split_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE)      split_done_r <= 1'b0;
      else if (state_r == S_DIR2) split_done_r <= 1'b1;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

[rtl/extendible_hash_table_core.sv]
// Top level of the extendible hash table: controller plus datapath.
//
// Usage: present a put or get item on in_valid/in_data; in_ready is high
// while the block is idle and the item is taken when both are high. Each
// item yields exactly one result item on out_valid/out_data, held in an
// output register until out_ready takes it.
// Sequence: the key is hashed, then the directory and the page table are
// read and the decision is made, then the slots of the page are read and
// compared one at a time through the slot memory read port, and the item
// finishes. A get stops comparing on an early hit; in_ready returns at the
// same edge at which the result becomes valid.
// A put that splits a page copies the directory entries when the
// directory doubles, reads every entry of the page and rehashes it
// through the one-byte-per-cycle hash unit, and then redirects the
// directory entries of the split page. One item is in flight at a time.
// Reset: the table is empty, global depth zero, every directory entry names
// page zero; valid bits give the directory and page table their reset
// values at once, so no clearing pass is needed.
// Stall: a finished item waits in the output register; the next item may
// be taken and worked on, and its result waits until the register frees.
module extendible_hash_table_core import ehash_pkg::*; #(
  parameter int BUCKET_LIMIT   = BUCKET_LIMIT_DEF,
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF,
  parameter int MAX_DEPTH      = MAX_DEPTH_DEF,
  parameter int KEY_BYTES      = KEY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ehash_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ehash_out_t out_data
);

  dp_op_t     op;
  dp_status_t st;

  // Sequence each item through lookup, doubling and split
  ehash_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  // Hold the tables and execute one command a cycle
  ehash_dp #(
    .BUCKET_LIMIT   (BUCKET_LIMIT),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .MAX_DEPTH      (MAX_DEPTH),
    .KEY_BYTES      (KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
